### src/bhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_pkg
// Shared codes and controller/datapath interface types for the heap queue.
// ---------------------------------------------------------------------------
package bhpq_pkg;

   // operation codes carried on the request channel
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_PUSH_START,
      OP_POP_READ,
      OP_POP_LOAD,
      OP_PEEK_READ,
      OP_PEEK_LOAD,
      OP_UP_READ,
      OP_UP_STEP,
      OP_DN_READ,
      OP_DN_STEP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        load_rsp;
      logic        rsp_root;
      logic [1:0]  rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic last_one;
      logic at_root;
      logic no_child;
      logic climb;
      logic descend;
   } dp_status_type;

endpackage
`default_nettype wire

### src/bhpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for push/pop/peek: steps the datapath through sift-up and
// sift-down levels and owns the response valid flag.
// ---------------------------------------------------------------------------
module bhpq_ctrl
   import bhpq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [CMD_W-1:0]     req_cmd,
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire dp_status_type        dp_status,
   output      dp_cmd_type           dp_cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_LD,
      S_PEEK_LD,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 root_ff, root_in;
   logic                 rsp_valid_ff;
   logic                 accept;
   op_type               op;
   logic                 load_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      op        = OP_IDLE;
      load_rsp  = 1'b0;
      state_in  = state_ff;
      status_in = status_ff;
      root_in   = root_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               root_in   = 1'b0;
               state_in  = S_DONE;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (dp_status.full) begin
                        status_in = ST_FULL;
                     end else begin
                        op       = OP_PUSH_START;
                        state_in = S_UP_RD;
                     end
                  end
                  CMD_POP: begin
                     if (dp_status.empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        op       = OP_POP_READ;
                        root_in  = 1'b1;
                        state_in = S_POP_LD;
                     end
                  end
                  CMD_PEEK: begin
                     if (dp_status.empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        op       = OP_PEEK_READ;
                        root_in  = 1'b1;
                        state_in = S_PEEK_LD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POP_LD: begin
            op       = OP_POP_LOAD;
            state_in = dp_status.last_one ? S_DONE : S_DN_RD;
         end
         S_PEEK_LD: begin
            op       = OP_PEEK_LOAD;
            state_in = S_DONE;
         end
         S_UP_RD: begin
            op       = OP_UP_READ;
            state_in = dp_status.at_root ? S_DONE : S_UP_CMP;
         end
         S_UP_CMP: begin
            op       = OP_UP_STEP;
            state_in = dp_status.climb ? S_UP_RD : S_DONE;
         end
         S_DN_RD: begin
            op       = OP_DN_READ;
            state_in = dp_status.no_child ? S_DONE : S_DN_CMP;
         end
         S_DN_CMP: begin
            op       = OP_DN_STEP;
            state_in = dp_status.descend ? S_DN_RD : S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            load_rsp = !rsp_valid_ff || rsp_tready;
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd.op         = op;
      dp_cmd.load_rsp   = load_rsp;
      dp_cmd.rsp_root   = root_ff;
      dp_cmd.rsp_status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         root_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         root_ff   <= root_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

### src/bhpq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_dpath
// Heap store, fill count, hole position, moving value, priority compare
// and response register. Sifts move a hole rather than swapping pairs.
// ---------------------------------------------------------------------------
module bhpq_dpath
   import bhpq_pkg::*;
#(
   parameter int unsigned DEPTH       = 64,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic                           csr_wdata,
   input  wire logic [VALUE_WIDTH-1:0]         req_value,
   input  wire dp_cmd_type                     dp_cmd,
   output      dp_status_type                  dp_status,
   output      logic [VALUE_WIDTH-1:0]         rsp_value,
   output      logic [STATUS_W-1:0]            rsp_status,
   output      logic [$clog2(DEPTH+1)-1:0]     rsp_count
);

   localparam int unsigned AW  = $clog2(DEPTH);
   localparam int unsigned CW  = $clog2(DEPTH + 1);
   localparam int unsigned CHW = AW + 2;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic                   larger_first_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] moving_ff, moving_in;
   logic [VALUE_WIDTH-1:0] res_ff, res_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [CW-1:0]          rsp_count_ff;

   logic                   we;
   logic [AW-1:0]          wa, ra, rb;
   logic [VALUE_WIDTH-1:0] wd;

   logic [CW-1:0]          count_m1;
   logic [AW-1:0]          parent;
   logic [CHW-1:0]         left, right, count_x;
   logic                   has_right, pick_right;
   logic [VALUE_WIDTH-1:0] pick_val;
   logic [AW-1:0]          pick_idx;
   logic                   climb, descend;

   function automatic logic outranks(input logic lf,
                                     input logic [VALUE_WIDTH-1:0] a,
                                     input logic [VALUE_WIDTH-1:0] b);
      outranks = lf ? (a > b) : (a < b);
   endfunction

   assign count_m1   = count_ff - CW'(1);
   assign parent     = (pos_ff - AW'(1)) >> 1;
   assign left       = CHW'({pos_ff, 1'b1});
   assign right      = left + CHW'(1);
   assign count_x    = CHW'(count_ff);
   assign has_right  = right < count_x;
   // right child wins a tie
   assign pick_right = has_right && !outranks(larger_first_ff, rd_a_ff, rd_b_ff);
   assign pick_val   = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];
   assign climb      = outranks(larger_first_ff, moving_ff, rd_a_ff);
   assign descend    = outranks(larger_first_ff, pick_val, moving_ff);

   always_comb begin
      dp_status.empty    = (count_ff == '0);
      dp_status.full     = (count_ff == CW'(DEPTH));
      dp_status.last_one = (count_ff == CW'(1));
      dp_status.at_root  = (pos_ff == '0);
      dp_status.no_child = (left >= count_x);
      dp_status.climb    = climb;
      dp_status.descend  = descend;
   end

   always_comb begin
      we        = 1'b0;
      wa        = pos_ff;
      wd        = moving_ff;
      ra        = '0;
      rb        = '0;
      count_in  = count_ff;
      pos_in    = pos_ff;
      moving_in = moving_ff;
      res_in    = res_ff;
      unique case (dp_cmd.op)
         OP_IDLE: ;
         OP_PUSH_START: begin
            pos_in    = count_ff[AW-1:0];
            count_in  = count_ff + CW'(1);
            moving_in = req_value;
         end
         OP_POP_READ: begin
            ra = '0;
            rb = count_m1[AW-1:0];
         end
         OP_POP_LOAD: begin
            res_in    = rd_a_ff;
            moving_in = rd_b_ff;
            count_in  = count_m1;
            pos_in    = '0;
         end
         OP_PEEK_READ: ra = '0;
         OP_PEEK_LOAD: res_in = rd_a_ff;
         OP_UP_READ: begin
            if (pos_ff == '0) begin
               we = 1'b1;
            end else begin
               ra = parent;
            end
         end
         OP_UP_STEP: begin
            we = 1'b1;
            if (climb) begin
               wd     = rd_a_ff;
               pos_in = parent;
            end
         end
         OP_DN_READ: begin
            if (left >= count_x) begin
               we = 1'b1;
            end else begin
               ra = left[AW-1:0];
               rb = right[AW-1:0];
            end
         end
         OP_DN_STEP: begin
            we = 1'b1;
            if (descend) begin
               wd     = pick_val;
               pos_in = pick_idx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_a_ff <= mem[ra];
      rd_b_ff <= mem[rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         larger_first_ff <= 1'b0;
         count_ff        <= '0;
      end else begin
         if (csr_we) begin
            larger_first_ff <= csr_wdata;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      moving_ff <= moving_in;
      res_ff    <= res_in;
      if (dp_cmd.load_rsp) begin
         rsp_value_ff  <= dp_cmd.rsp_root ? res_ff : '0;
         rsp_status_ff <= dp_cmd.rsp_status;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
`default_nettype wire

### src/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// From accept to response valid: empty/full/unused commands go straight to the
// response; peek reads the root, then loads it; push and pop step level by level,
// pop first reading and loading the root and last entry and skipping the descent when
// it empties the queue. Each level is a registered store read, then compare/write.
// One transaction in flight; the next is taken the cycle after its response is
// loaded into the output register. Synchronous reset empties the queue, smallest first.
// ---------------------------------------------------------------------------
// binary_heap_priority_queue
// Array-backed binary heap priority queue with push, pop and peek.
// ---------------------------------------------------------------------------
module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int unsigned DEPTH       = 64,
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_wdata,             // larger_first
   input  wire logic req_tvalid,
   output      logic req_tready,
   // value
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // cmd
   input  wire logic [CMD_W-1:0] req_tuser,
   output      logic rsp_tvalid,
   input  wire logic rsp_tready,
   // result_value, entry_count
   output      logic [((VALUE_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] rsp_tdata,
   // status
   output      logic [STATUS_W-1:0] rsp_tuser
);

   localparam int unsigned CW     = $clog2(DEPTH + 1);
   localparam int unsigned RSP_TW = ((VALUE_WIDTH + CW + 7) / 8) * 8;

   dp_cmd_type              dp_cmd;
   dp_status_type           dp_status;
   logic [VALUE_WIDTH-1:0]  rsp_value;
   logic [STATUS_W-1:0]     rsp_status;
   logic [CW-1:0]           rsp_count;

   bhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   bhpq_dpath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_value  (req_tdata[VALUE_WIDTH-1:0]),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = RSP_TW'({rsp_count, rsp_value});
   assign rsp_tuser = rsp_status;

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= CW'(DEPTH)))
      else $error("entry count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_FULL) |-> (rsp_count == CW'(DEPTH)))
      else $error("full status with free entries");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_EMPTY) |-> (rsp_count == '0 && rsp_value == '0))
      else $error("empty status with entries or a value");

endmodule
`default_nettype wire

### verif/tb_binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_binary_heap_priority_queue
// Checks push, pop and peek transactions against a behavioural copy of the
// heap. Starts with a short directed run, then random fill/drain runs under
// both orderings, all but the last with random back-pressure on either side.
// ---------------------------------------------------------------------------
module tb_binary_heap_priority_queue;
   import bhpq_pkg::*;

   localparam int unsigned DEPTH       = 64;
   localparam int unsigned VALUE_WIDTH = 16;
   localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
   localparam int unsigned REQ_W       = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int unsigned RSP_W       = ((VALUE_WIDTH + COUNT_W + 7) / 8) * 8;

   // the fourth command code does nothing
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef logic [VALUE_WIDTH-1:0] heap_value_type;

   typedef struct packed {
      heap_value_type       value;
      logic [STATUS_W-1:0]  status;
      logic [COUNT_W-1:0]   count;
   } heap_reply_type;

   // ------------------------------------------------------------------------
   // scoreboard: mirrors the heap and queues the reply due for each command
   // ------------------------------------------------------------------------
   class heap_tracker;
      heap_value_type  slots [DEPTH];
      int unsigned     fill;
      bit              larger_first;
      heap_reply_type  replies_due [$];
      int unsigned     errors;

      function bit wins_over(heap_value_type a, heap_value_type b);
         return larger_first ? (a > b) : (a < b);
      endfunction

      function void swap_slots(int unsigned i, int unsigned j);
         heap_value_type t;
         t        = slots[i];
         slots[i] = slots[j];
         slots[j] = t;
      endfunction

      function int unsigned pending();
         return replies_due.size();
      endfunction

      function void apply_command(logic [CMD_W-1:0] cmd, heap_value_type val);
         heap_reply_type r;
         int unsigned pos, up, kid;
         bit moving;
         r = '0;
         case (cmd)
            CMD_PUSH: begin
               if (fill >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  pos = fill;
                  slots[pos] = val;
                  fill++;
                  moving = 1'b1;
                  while (moving && pos > 0) begin
                     up = (pos - 1) / 2;
                     if (wins_over(slots[pos], slots[up])) begin
                        swap_slots(pos, up);
                        pos = up;
                     end else begin
                        moving = 1'b0;
                     end
                  end
               end
            end
            CMD_POP: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.value = slots[0];
                  fill--;
                  slots[0] = slots[fill];
                  pos = 0;
                  moving = 1'b1;
                  while (moving && 2 * pos + 1 < fill) begin
                     kid = 2 * pos + 1;
                     // right child wins a tie
                     if (kid + 1 < fill && !wins_over(slots[kid], slots[kid + 1]))
                        kid = kid + 1;
                     if (wins_over(slots[kid], slots[pos])) begin
                        swap_slots(pos, kid);
                        pos = kid;
                     end else begin
                        moving = 1'b0;
                     end
                  end
               end
            end
            CMD_PEEK: begin
               if (fill == 0)
                  r.status = ST_EMPTY;
               else
                  r.value = slots[0];
            end
            default: ;
         endcase
         r.status = (r.status == ST_OK) ? ST_OK : r.status;
         r.count  = COUNT_W'(fill);
         replies_due.insert(replies_due.size(), r);
      endfunction

      function void check_reply(heap_value_type v, logic [STATUS_W-1:0] s,
                                logic [COUNT_W-1:0] c);
         heap_reply_type e;
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: value %h status %0d count %0d",
                     $time, v, s, c);
            return;
         end
         e = replies_due.pop_front();
         if (v !== e.value) begin
            errors++;
            $display("%0t: result_value expected %h actual %h", $time, e.value, v);
         end
         if (s !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, s);
         end
         if (c !== e.count) begin
            errors++;
            $display("%0t: entry_count expected %0d actual %0d", $time, e.count, c);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0]    req_tdata;   // value
   logic [CMD_W-1:0]    req_tuser;   // cmd
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // result_value, entry_count
   logic [STATUS_W-1:0] rsp_tuser;   // status

   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;

   heap_tracker tracker = new();

   binary_heap_priority_queue #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // values biased towards the extremes and towards ties
   function automatic heap_value_type random_value();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2, 3:    return heap_value_type'($urandom_range(7));
         default: return heap_value_type'($urandom);
      endcase
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd, input heap_value_type val);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'(val);
      do @(posedge clock); while (!req_tready);
      tracker.apply_command(cmd, val);
   endtask

   // only called with the queue idle; the heap may still hold entries
   task automatic set_priority_order(input bit larger);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= larger;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.larger_first = larger;
   endtask

   // alternating fill and drain runs so that full and empty are both reached
   task automatic run_phase(input int unsigned n_items);
      int unsigned sent, seg_len, push_pct, roll;
      bit filling;
      logic [CMD_W-1:0] cmd;
      sent    = 0;
      filling = 1'b1;
      while (sent < n_items) begin
         seg_len  = filling ? $urandom_range(80, 60) : $urandom_range(75, 40);
         push_pct = filling ? 92 : 15;
         for (int i = 0; i < seg_len && sent < n_items; i++) begin
            if ($urandom_range(99) < push_pct) begin
               cmd = CMD_PUSH;
            end else begin
               roll = $urandom_range(9);
               cmd  = (roll < 7) ? CMD_POP : (roll < 9) ? CMD_PEEK : CMD_UNUSED;
            end
            send_request(cmd, random_value());
            sent++;
         end
         filling = !filling;
      end
   endtask

   // response side: check on each accepted transaction, stall at random
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_reply(rsp_tdata[VALUE_WIDTH-1:0], rsp_tuser,
                                rsp_tdata[VALUE_WIDTH+COUNT_W-1:VALUE_WIDTH]);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_PUSH;
      send_gap_pct   = 32;
      recv_stall_pct = 58;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_priority_order(1'b0);

      // directed: empty queue, unused code, extremes, ties
      send_request(CMD_PEEK, 16'h5a5a);
      send_request(CMD_POP, 16'hffff);
      send_request(CMD_UNUSED, 16'hffff);
      send_request(CMD_PUSH, 16'hffff);
      send_request(CMD_PUSH, 16'h0000);
      send_request(CMD_PUSH, 16'h8000);
      send_request(CMD_PUSH, 16'h0001);
      send_request(CMD_PUSH, 16'h0001);
      send_request(CMD_PEEK, 16'h0000);
      send_request(CMD_UNUSED, 16'h0000);
      repeat (5) send_request(CMD_POP, random_value());
      send_request(CMD_POP, 16'h0000);
      send_request(CMD_PEEK, 16'hffff);
      repeat (3) send_request(CMD_PUSH, 16'h1234);
      send_request(CMD_PUSH, 16'h7fff);
      repeat (3) send_request(CMD_POP, random_value());

      // heap left non-empty across each ordering change
      set_priority_order(1'b1);
      run_phase(130);

      set_priority_order(1'b0);
      send_gap_pct   = 58;
      recv_stall_pct = 32;
      run_phase(130);

      set_priority_order(1'b1);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      run_phase(130);

      req_tvalid <= 1'b0;
      for (int n = 0; n < 5000 && tracker.pending() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.errors++;
         $display("%0t: %0d responses never arrived", $time, tracker.pending());
      end
      if (tracker.errors == 0)
         $display("tb_binary_heap_priority_queue passed");
      else
         $display("tb_binary_heap_priority_queue failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_binary_heap_priority_queue failed");
      $finish;
   end

endmodule
